// ----- hdl/ibc_pkg.sv -----
// Shared widths, constants and the arctangent table for the isotropic binary
// collision pipeline. Used by the top level, the square root and the CORDIC unit.
// No dependencies.
`default_nettype none

package ibc_pkg;

	// Field widths
	localparam int VEL_W      = 32;
	localparam int MASS_W     = 32;
	localparam int FRAC_W     = 32;
	localparam int SPC_IN_W   = 2;
	localparam int CFG_IDX_W  = 2;

	// Configuration
	localparam int             NUM_MASS_REGS   = 4;
	localparam int             DEF_NUM_SPECIES = 4;
	localparam logic [MASS_W-1:0] MASS_RESET   = 32'd65536;

	// Q1.30 weights
	localparam int             W_W         = 31;
	localparam logic [W_W-1:0] ONE_Q30     = 31'h4000_0000;
	localparam logic [W_W-1:0] HALF_Q30    = 31'h2000_0000;
	localparam logic [W_W-1:0] HALF_PI_Q30 = 31'd1686629713;

	// Square root unit
	localparam int RAD_W      = 66;
	localparam int ROOT_W     = 33;
	localparam int REM_W      = 36;
	localparam int SQRT_STEPS = 33;

	// Weight divider
	localparam int DIV_STEPS  = 31;
	localparam int TOT_W      = 33;
	localparam int NUM_W      = 63;

	// CORDIC unit
	localparam int                 CS_W         = 34;
	localparam int                 Z_W          = 33;
	localparam int                 CORDIC_STEPS = 31;
	localparam logic [CS_W-1:0]    CORDIC_GAIN  = 34'd652032874;

	// Arctangent of 2^-i in Q2.30 radians
	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		logic [31:0] a;
		begin
			case (i)
				5'd0:  a = 32'h3243F6A8;
				5'd1:  a = 32'h1DAC6705;
				5'd2:  a = 32'h0FADBAFC;
				5'd3:  a = 32'h07F56EA6;
				5'd4:  a = 32'h03FEAB76;
				5'd5:  a = 32'h01FFD55B;
				5'd6:  a = 32'h00FFFAAA;
				5'd7:  a = 32'h007FFF55;
				5'd8:  a = 32'h003FFFEA;
				5'd9:  a = 32'h001FFFFD;
				5'd10: a = 32'h000FFFFF;
				5'd11: a = 32'h0007FFFF;
				5'd12: a = 32'h0003FFFF;
				5'd13: a = 32'h0001FFFF;
				5'd14: a = 32'h0000FFFF;
				5'd15: a = 32'h00007FFF;
				5'd16: a = 32'h00003FFF;
				5'd17: a = 32'h00001FFF;
				5'd18: a = 32'h00000FFF;
				5'd19: a = 32'h000007FF;
				5'd20: a = 32'h000003FF;
				5'd21: a = 32'h000001FF;
				5'd22: a = 32'h000000FF;
				5'd23: a = 32'h0000007F;
				5'd24: a = 32'h0000003F;
				5'd25: a = 32'h0000001F;
				5'd26: a = 32'h0000000F;
				5'd27: a = 32'h00000008;
				5'd28: a = 32'h00000004;
				5'd29: a = 32'h00000002;
				5'd30: a = 32'h00000001;
				default: a = 32'h00000000;
			endcase
			return a;
		end
	endfunction

endpackage

`default_nettype wire

// ----- hdl/ibc_isqrt.sv -----
// Pipelined floor square root of a 66-bit radicand, one result bit per stage.
// Depends on ibc_pkg.
`default_nettype none

module ibc_isqrt
	import ibc_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [RAD_W-1:0]  rad,
	output logic [ROOT_W-1:0] root
);

	logic [ROOT_W-1:0] root_s [1:SQRT_STEPS];
	logic [REM_W-1:0]  rem_s  [1:SQRT_STEPS-1];
	logic [RAD_W-1:0]  rad_s  [1:SQRT_STEPS-1];

	genvar j;
	generate
		for (j = 0; j < SQRT_STEPS; j++) begin : g_step
			localparam int BIT = 2 * (SQRT_STEPS - 1 - j);
			logic [ROOT_W-1:0] root_in;
			logic [REM_W-1:0]  rem_in;
			logic [REM_W-1:0]  rem_sh;
			logic [REM_W-1:0]  trial;
			logic [RAD_W-1:0]  rad_in;
			logic              ge;

			if (j == 0) begin : g_first
				assign root_in = '0;
				assign rem_in  = '0;
				assign rad_in  = rad;
			end else begin : g_next
				assign root_in = root_s[j];
				assign rem_in  = rem_s[j];
				assign rad_in  = rad_s[j];
			end

			// bring down the next bit pair and try the trial subtrahend
			always_comb begin
				rem_sh = {rem_in[REM_W-3:0], rad_in[BIT+1:BIT]};
				trial  = {1'b0, root_in, 2'b01};
				ge     = (rem_sh >= trial);
			end

			always_ff @(posedge clk) begin
				if (en) begin
					root_s[j+1] <= {root_in[ROOT_W-2:0], ge};
				end
			end

			// carry remainder and radicand only while later steps need them
			if (j < SQRT_STEPS - 1) begin : g_carry
				always_ff @(posedge clk) begin
					if (en) begin
						rem_s[j+1] <= ge ? rem_sh - trial : rem_sh;
						rad_s[j+1] <= rad_in;
					end
				end
			end
		end
	endgenerate

	assign root = root_s[SQRT_STEPS];

endmodule

`default_nettype wire

// ----- hdl/ibc_cordic.sv -----
// Pipelined rotation-mode CORDIC: cosine and sine of a Q1.30 angle, one
// micro-rotation per stage, quadrant code carried alongside. Depends on ibc_pkg.
`default_nettype none

module ibc_cordic
	import ibc_pkg::*;
(
	input  logic            clk,
	input  logic            en,
	input  logic [30:0]     ang,
	input  logic [1:0]      quad_in,
	output logic [CS_W-1:0] cos_out,
	output logic [CS_W-1:0] sin_out,
	output logic [1:0]      quad_out
);

	logic signed [CS_W-1:0] x_s [1:CORDIC_STEPS];
	logic signed [CS_W-1:0] y_s [1:CORDIC_STEPS];
	logic signed [Z_W-1:0]  z_s [1:CORDIC_STEPS-1];
	logic [1:0]             q_s [1:CORDIC_STEPS];

	genvar j;
	generate
		for (j = 0; j < CORDIC_STEPS; j++) begin : g_step
			logic signed [CS_W-1:0] x_in;
			logic signed [CS_W-1:0] y_in;
			logic signed [Z_W-1:0]  z_in;
			logic [1:0]             q_in;
			logic signed [CS_W-1:0] dx;
			logic signed [CS_W-1:0] dy;
			logic signed [Z_W-1:0]  at;

			if (j == 0) begin : g_first
				assign x_in = CORDIC_GAIN;
				assign y_in = '0;
				assign z_in = {2'b00, ang};
				assign q_in = quad_in;
			end else begin : g_next
				assign x_in = x_s[j];
				assign y_in = y_s[j];
				assign z_in = z_s[j];
				assign q_in = q_s[j];
			end

			// shifts round toward minus infinity
			always_comb begin
				dx = y_in >>> j;
				dy = x_in >>> j;
				at = {1'b0, atan_q30(5'(j))};
			end

			always_ff @(posedge clk) begin
				if (en) begin
					if (!z_in[Z_W-1]) begin
						x_s[j+1] <= x_in - dx;
						y_s[j+1] <= y_in + dy;
					end else begin
						x_s[j+1] <= x_in + dx;
						y_s[j+1] <= y_in - dy;
					end
					q_s[j+1] <= q_in;
				end
			end

			if (j < CORDIC_STEPS - 1) begin : g_angle
				always_ff @(posedge clk) begin
					if (en) begin
						z_s[j+1] <= z_in[Z_W-1] ? z_in + at : z_in - at;
					end
				end
			end
		end
	endgenerate

	assign cos_out  = x_s[CORDIC_STEPS];
	assign sin_out  = y_s[CORDIC_STEPS];
	assign quad_out = q_s[CORDIC_STEPS];

endmodule

`default_nettype wire

// ----- hdl/isotropic_binary_collision_top.sv -----
// Isotropic binary collision kernel. One particle pair enters per clock and its
// two post-collision velocities leave from the result stage; the pipeline keeps one
// pair per cycle as long as it is not held. The depth is set by the two 33-step square
// roots (relative speed and polar sine), which run beside a 31-step weight divider and
// a 31-step CORDIC for the azimuth. When the result stage is full and not taken the whole
// pipeline holds. The user must write mass registers through the cfg port only while
// idle; the block does not enforce this. Depends on ibc_pkg, ibc_isqrt and ibc_cordic.
`default_nettype none

module isotropic_binary_collision_top
	import ibc_pkg::*;
#(
	parameter int NUM_SPECIES = DEF_NUM_SPECIES
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	// vel_p_x, vel_p_y, vel_p_z, vel_q_x, vel_q_y, vel_q_z, rand_cos, rand_phi
	input  logic [255:0]         s_tdata,
	// species_p, species_q
	input  logic [3:0]           s_tuser,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// new_p_x, new_p_y, new_p_z, new_q_x, new_q_y, new_q_z
	output logic [191:0]         m_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [MASS_W-1:0]    cfg_data
);

	localparam int SPC_W = $clog2(NUM_SPECIES);
	localparam int LAT   = 42;

	localparam logic [1:0] QUAD_0   = 2'd0;
	localparam logic [1:0] QUAD_90  = 2'd1;
	localparam logic [1:0] QUAD_180 = 2'd2;

	typedef struct packed {
		logic [2:0][31:0] p;
		logic [2:0][32:0] d;
		logic [31:0]      c;
	} pdc_t;

	logic             en;
	logic [LAT:1]     vld_s;
	logic [MASS_W-1:0] mass_q [NUM_SPECIES];

	// ---------------------------------------------------------------- handshake
	assign en       = !vld_s[LAT] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_s[LAT];

	// advance valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-1:1], s_tvalid};
		end
	end

	// ---------------------------------------------------------------- mass registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_SPECIES; k++) mass_q[k] <= MASS_RESET;
		end else if (cfg_we) begin
			for (int k = 0; k < NUM_SPECIES; k++) begin
				if (k < NUM_MASS_REGS && cfg_idx == CFG_IDX_W'(k)) mass_q[k] <= cfg_data;
			end
		end
	end

	// wrap the species code into the table
	function automatic logic [SPC_W-1:0] spc_wrap(input logic [SPC_IN_W-1:0] s);
		logic [3:0] w;
		begin
			w = {2'b00, s};
			if (w >= 4'(NUM_SPECIES)) w = w - 4'(NUM_SPECIES);
			return SPC_W'(w);
		end
	endfunction

	logic [SPC_W-1:0]  spc_p, spc_q;
	logic [MASS_W-1:0] mp_sel, mq_sel;

	always_comb begin
		spc_p  = spc_wrap(s_tuser[1:0]);
		spc_q  = spc_wrap(s_tuser[3:2]);
		mp_sel = '0;
		mq_sel = '0;
		for (int k = 0; k < NUM_SPECIES; k++) begin
			if (spc_p == SPC_W'(k)) mp_sel = mass_q[k];
			if (spc_q == SPC_W'(k)) mq_sel = mass_q[k];
		end
	end

	// ---------------------------------------------------------------- helpers
	function automatic logic [31:0] abs33(input logic [32:0] v);
		logic [32:0] a;
		begin
			a = v[32] ? (~v + 33'd1) : v;
			return a[31:0];
		end
	endfunction

	function automatic logic [31:0] abs32(input logic [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

	function automatic logic [39:0] sgn38(input logic [37:0] m, input logic neg);
		logic [39:0] e;
		begin
			e = {2'b00, m};
			return neg ? (~e + 40'd1) : e;
		end
	endfunction

	function automatic logic [31:0] sat40(input logic [39:0] v);
		logic [31:0] r;
		begin
			if (v[39:31] == {9{v[39]}}) r = v[31:0];
			else if (v[39])             r = 32'h8000_0000;
			else                        r = 32'h7FFF_FFFF;
			return r;
		end
	endfunction

	// ---------------------------------------------------------------- front stages
	logic [31:0]   p_s1 [3];
	logic [32:0]   d_s1 [3];
	logic [MASS_W-1:0] mp_s1, mq_s1;
	logic [31:0]   c_s1;
	logic [FRAC_W-1:0] phi_s1;

	logic [31:0]   p_s2 [3];
	logic [32:0]   d_s2 [3];
	logic [31:0]   c_s2;
	logic [63:0]   sq_s2 [3];
	logic [63:0]   csq_s2;
	logic [30:0]   z_s2;
	logic [1:0]    quad_s2;
	logic [TOT_W-1:0] tot_s2;
	logic [NUM_W-1:0] num_s2;

	logic [RAD_W-1:0] rsum_s3, srad_s3;
	logic [30:0]   z_s3;
	logic [1:0]    quad_s3;
	logic [TOT_W-1:0] tot_s3;
	logic [NUM_W-1:0] num_s3;

	pdc_t          dly_s [3:36];

	logic [31:0]   dabs1 [3];
	logic [31:0]   cabs1;
	logic [60:0]   zprod;
	logic [TOT_W-1:0] tot1;

	always_comb begin
		for (int k = 0; k < 3; k++) dabs1[k] = abs33(d_s1[k]);
		cabs1 = abs32(c_s1);
		zprod = phi_s1[29:0] * HALF_PI_Q30;
		tot1  = {1'b0, mp_s1} + {1'b0, mq_s1};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: register the request, form differences, pick masses
			for (int k = 0; k < 3; k++) begin
				p_s1[k] <= s_tdata[32*k +: 32];
				d_s1[k] <= {s_tdata[32*k+31], s_tdata[32*k +: 32]}
				         - {s_tdata[96+32*k+31], s_tdata[96+32*k +: 32]};
			end
			mp_s1  <= mp_sel;
			mq_s1  <= mq_sel;
			c_s1   <= {~s_tdata[223], s_tdata[222:192]};
			phi_s1 <= s_tdata[255:224];

			// stage 2: squares, azimuth angle, weight numerator
			for (int k = 0; k < 3; k++) begin
				p_s2[k]  <= p_s1[k];
				d_s2[k]  <= d_s1[k];
				sq_s2[k] <= dabs1[k] * dabs1[k];
			end
			c_s2    <= c_s1;
			csq_s2  <= cabs1 * cabs1;
			z_s2    <= zprod[60:30];
			quad_s2 <= phi_s1[31:30];
			tot_s2  <= tot1;
			num_s2  <= {1'b0, mq_s1, 30'b0} + {31'b0, tot1[TOT_W-1:1]};

			// stage 3: radicands
			rsum_s3 <= {2'b00, sq_s2[0]} + {2'b00, sq_s2[1]} + {2'b00, sq_s2[2]};
			srad_s3 <= {2'b00, 64'h4000_0000_0000_0000 - csq_s2};
			z_s3    <= z_s2;
			quad_s3 <= quad_s2;
			tot_s3  <= tot_s2;
			num_s3  <= num_s2;
			for (int k = 0; k < 3; k++) begin
				dly_s[3].p[k] <= p_s2[k];
				dly_s[3].d[k] <= d_s2[k];
			end
			dly_s[3].c <= c_s2;

			// hold operands until the square roots finish
			for (int k = 4; k <= 36; k++) dly_s[k] <= dly_s[k-1];
		end
	end

	// ---------------------------------------------------------------- square roots
	logic [ROOT_W-1:0] cr_root, s_root;

	ibc_isqrt u_sqrt_speed (
		.clk  (clk),
		.en   (en),
		.rad  (rsum_s3),
		.root (cr_root)
	);

	ibc_isqrt u_sqrt_sine (
		.clk  (clk),
		.en   (en),
		.rad  (srad_s3),
		.root (s_root)
	);

	// ---------------------------------------------------------------- weight divider
	logic [TOT_W-1:0] dv_rem_s [4:33];
	logic [NUM_W-1:0] dv_num_s [4:33];
	logic [W_W-1:0]   dv_q_s   [4:34];
	logic [TOT_W-1:0] dv_tot_s [4:34];

	genvar j;
	generate
		for (j = 0; j < DIV_STEPS; j++) begin : g_div
			localparam int QB = DIV_STEPS - 1 - j;
			logic [TOT_W-1:0] rem_in, tot_in;
			logic [NUM_W-1:0] num_in;
			logic [W_W-1:0]   q_in, q_nx;
			logic [TOT_W:0]   r2, diff;
			logic             ge;

			if (j == 0) begin : g_first
				assign rem_in = {1'b0, num_s3[NUM_W-1:DIV_STEPS]};
				assign num_in = num_s3;
				assign q_in   = '0;
				assign tot_in = tot_s3;
			end else begin : g_next
				assign rem_in = dv_rem_s[3+j];
				assign num_in = dv_num_s[3+j];
				assign q_in   = dv_q_s[3+j];
				assign tot_in = dv_tot_s[3+j];
			end

			// restoring step: one quotient bit
			always_comb begin
				r2       = {rem_in, num_in[QB]};
				diff     = r2 - {1'b0, tot_in};
				ge       = (r2 >= {1'b0, tot_in});
				q_nx     = q_in;
				q_nx[QB] = ge;
			end

			always_ff @(posedge clk) begin
				if (en) begin
					dv_q_s[4+j]   <= q_nx;
					dv_tot_s[4+j] <= tot_in;
				end
			end

			if (j < DIV_STEPS - 1) begin : g_carry
				always_ff @(posedge clk) begin
					if (en) begin
						dv_rem_s[4+j] <= ge ? diff[TOT_W-1:0] : r2[TOT_W-1:0];
						dv_num_s[4+j] <= num_in;
					end
				end
			end
		end
	endgenerate

	// ---------------------------------------------------------------- azimuth
	logic [CS_W-1:0] cx_s34, cy_s34;
	logic [1:0]      cq_s34;

	ibc_cordic u_cordic (
		.clk      (clk),
		.en       (en),
		.ang      (z_s3),
		.quad_in  (quad_s3),
		.cos_out  (cx_s34),
		.sin_out  (cy_s34),
		.quad_out (cq_s34)
	);

	// ---------------------------------------------------------------- back stages
	logic [W_W-1:0]  wq_s35, wq_s36, wp_s36;
	logic [CS_W-1:0] cphi_s35, sphi_s35, cphi_s36, sphi_s36;

	logic [64:0]     gxp_s37, tp_s37;
	logic            gxn_s37;
	logic [62:0]     up_s37 [3];
	logic            un_s37 [3];
	logic [31:0]     p_s37 [3];
	logic [W_W-1:0]  wq_s37, wp_s37, wq_s38, wp_s38, wq_s39, wp_s39, wq_s40, wp_s40;
	logic [CS_W-1:0] cphi_s37, sphi_s37, cphi_s38, sphi_s38;

	logic [36:0]     gm_s38, gm_s39;
	logic            gn_s38, gn_s39;
	logic [33:0]     t_s38;
	logic [34:0]     ucm_s38 [3];
	logic [34:0]     ucm_s39 [3];
	logic [66:0]     gyp_s39, gzp_s39;
	logic            gyn_s39, gzn_s39;

	logic [36:0]     gm_s40 [3];
	logic            gn_s40 [3];
	logic [34:0]     ucm_s40 [3];

	logic [67:0]     ap_s41 [3];
	logic [67:0]     bp_s41 [3];
	logic            gn_s41 [3];
	logic [34:0]     ucm_s41 [3];

	logic [31:0]     newp_s42 [3];
	logic [31:0]     newq_s42 [3];

	logic [31:0]     dabs36 [3];
	logic [31:0]     cabs36;
	logic [32:0]     uterm [3];
	logic [34:0]     uoff [3];
	logic [CS_W-1:0] cphi_abs, sphi_abs;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dabs36[k] = abs33(dly_s[36].d[k]);
			uterm[k]  = up_s37[k][62:30];
			uoff[k]   = un_s37[k] ? (~{2'b00, uterm[k]} + 35'd1) : {2'b00, uterm[k]};
		end
		cabs36   = abs32(dly_s[36].c);
		cphi_abs = cphi_s38[CS_W-1] ? (~cphi_s38 + 34'd1) : cphi_s38;
		sphi_abs = sphi_s38[CS_W-1] ? (~sphi_s38 + 34'd1) : sphi_s38;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 35: pick weight, rotate azimuth into its quadrant
			wq_s35 <= (dv_tot_s[34] == '0) ? HALF_Q30 : dv_q_s[34];
			case (cq_s34)
				QUAD_0: begin
					cphi_s35 <= cx_s34;
					sphi_s35 <= cy_s34;
				end
				QUAD_90: begin
					cphi_s35 <= ~cy_s34 + 34'd1;
					sphi_s35 <= cx_s34;
				end
				QUAD_180: begin
					cphi_s35 <= ~cx_s34 + 34'd1;
					sphi_s35 <= ~cy_s34 + 34'd1;
				end
				default: begin
					cphi_s35 <= cy_s34;
					sphi_s35 <= ~cx_s34 + 34'd1;
				end
			endcase

			// stage 36: join with the square roots
			wq_s36   <= wq_s35;
			wp_s36   <= ONE_Q30 - wq_s35;
			cphi_s36 <= cphi_s35;
			sphi_s36 <= sphi_s35;

			// stage 37: speed products and centre-of-mass offsets
			gxp_s37 <= cr_root * cabs36;
			gxn_s37 <= dly_s[36].c[31];
			tp_s37  <= cr_root * s_root[31:0];
			for (int k = 0; k < 3; k++) begin
				up_s37[k] <= dabs36[k] * wq_s36;
				un_s37[k] <= dly_s[36].d[k][32];
				p_s37[k]  <= dly_s[36].p[k];
			end
			wq_s37   <= wq_s36;
			wp_s37   <= wp_s36;
			cphi_s37 <= cphi_s36;
			sphi_s37 <= sphi_s36;

			// stage 38: scale down, form centre-of-mass velocity
			gm_s38 <= {3'b000, gxp_s37[64:31]};
			gn_s38 <= gxn_s37;
			t_s38  <= tp_s37[64:31];
			for (int k = 0; k < 3; k++) begin
				ucm_s38[k] <= {{3{p_s37[k][31]}}, p_s37[k]} - uoff[k];
			end
			wq_s38   <= wq_s37;
			wp_s38   <= wp_s37;
			cphi_s38 <= cphi_s37;
			sphi_s38 <= sphi_s37;

			// stage 39: transverse products
			gyp_s39 <= t_s38 * cphi_abs[32:0];
			gyn_s39 <= cphi_s38[CS_W-1];
			gzp_s39 <= t_s38 * sphi_abs[32:0];
			gzn_s39 <= sphi_s38[CS_W-1];
			gm_s39  <= gm_s38;
			gn_s39  <= gn_s38;
			for (int k = 0; k < 3; k++) ucm_s39[k] <= ucm_s38[k];
			wq_s39 <= wq_s38;
			wp_s39 <= wp_s38;

			// stage 40: relative velocity as sign and magnitude
			gm_s40[0] <= gm_s39;
			gn_s40[0] <= gn_s39;
			gm_s40[1] <= gyp_s39[66:30];
			gn_s40[1] <= gyn_s39;
			gm_s40[2] <= gzp_s39[66:30];
			gn_s40[2] <= gzn_s39;
			for (int k = 0; k < 3; k++) ucm_s40[k] <= ucm_s39[k];
			wq_s40 <= wq_s39;
			wp_s40 <= wp_s39;

			// stage 41: weight the relative velocity
			for (int k = 0; k < 3; k++) begin
				ap_s41[k]  <= gm_s40[k] * wq_s40;
				bp_s41[k]  <= gm_s40[k] * wp_s40;
				gn_s41[k]  <= gn_s40[k];
				ucm_s41[k] <= ucm_s40[k];
			end

			// stage 42: recombine and saturate
			for (int k = 0; k < 3; k++) begin
				newp_s42[k] <= sat40({{5{ucm_s41[k][34]}}, ucm_s41[k]}
				                     + sgn38(ap_s41[k][67:30], gn_s41[k]));
				newq_s42[k] <= sat40({{5{ucm_s41[k][34]}}, ucm_s41[k]}
				                     - sgn38(bp_s41[k][67:30], gn_s41[k]));
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			m_tdata[32*k +: 32]      = newp_s42[k];
			m_tdata[96 + 32*k +: 32] = newq_s42[k];
		end
	end

	// ---------------------------------------------------------------- checks
	a_stall_holds_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s))
		else $error("valid bits moved during a stall");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_s[1])
		else $error("accepted request did not enter stage 1");

	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[35] |-> wq_s35 <= ONE_Q30)
		else $error("mass weight above one");

	a_sine_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[36] |-> s_root <= 33'h0_8000_0000)
		else $error("polar sine above one");

endmodule

`default_nettype wire
